@@ rtl/qwmi_pkg.sv @@
// Package for the queue with middle insertion.
// Holds command codes, the internal operation and state types and the request struct.
// No dependencies.
`timescale 1ns / 1ps

package qwmi_pkg;

    // Command codes as they arrive on the input channel.
    localparam logic [1:0] CMD_PUSH_BACK   = 2'd0;
    localparam logic [1:0] CMD_PUSH_MIDDLE = 2'd1;
    localparam logic [1:0] CMD_POP         = 2'd2;

    // Operation handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_PUSH_BACK   = 2'd0,
        OP_PUSH_MIDDLE = 2'd1,
        OP_POP         = 2'd2
    } t_op;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_STEP1 = 3'b010,
        S_STEP2 = 3'b100
    } t_state;

    // Control half of a queued request.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_req_ctl;

endpackage

@@ rtl/qwmi_ram.sv @@
// Generic single-port RAM with a registered read. No dependencies.
// The user makes one access per cycle, either a write or a read; the RAM does not enforce it.
`timescale 1ns / 1ps

module qwmi_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // The read data register holds its value until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/qwmi_front.sv @@
// Front part: accepts commands, drops those that can never take effect,
// and holds the rest in a two-entry request queue. Uses qwmi_pkg.
`timescale 1ns / 1ps

module qwmi_front #(
    parameter int MAX_ID = 1023,
    parameter int ID_W   = $clog2(MAX_ID + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_command,
    input  logic [ID_W-1:0]     i_item_id,
    output qwmi_pkg::t_req_ctl  o_req,
    output logic [ID_W-1:0]     o_req_id,
    input  logic                i_take
);

    import qwmi_pkg::*;

    localparam logic [ID_W-1:0] MaxIdW = ID_W'(MAX_ID);

    t_op             r_op [2];
    logic [ID_W-1:0] r_id [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    logic keep;
    t_op  cmd_op;
    logic push;

    // Classify the command; invalid codes and out-of-range pushes are dropped here.
    always_comb begin
        keep   = 1'b0;
        cmd_op = OP_POP;
        unique case (i_command)
            CMD_PUSH_BACK: begin
                cmd_op = OP_PUSH_BACK;
                keep   = (i_item_id != '0) && (i_item_id <= MaxIdW);
            end
            CMD_PUSH_MIDDLE: begin
                cmd_op = OP_PUSH_MIDDLE;
                keep   = (i_item_id != '0) && (i_item_id <= MaxIdW);
            end
            CMD_POP: begin
                cmd_op = OP_POP;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_count == 2'd2);
    assign push    = i_valid && !o_stall && keep;

    // Occupancy of the request queue.
    always_comb begin
        n_count = r_count;
        if (push && !i_take) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_take) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Queue entries carry no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wr_ptr] <= cmd_op;
            r_id[r_wr_ptr] <= i_item_id;
        end
    end

    assign o_req.valid = (r_count != 2'd0);
    assign o_req.op    = r_op[r_rd_ptr];
    assign o_req_id    = r_id[r_rd_ptr];

endmodule

@@ rtl/qwmi_back.sv @@
// Back part: carries out queued requests on the linked list held in the
// link memory, and presents served identifiers in an output register.
// Uses qwmi_pkg and qwmi_ram.
`timescale 1ns / 1ps

module qwmi_back #(
    parameter int MAX_ID = 1023,
    parameter int ID_W   = $clog2(MAX_ID + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qwmi_pkg::t_req_ctl  i_req,
    input  logic [ID_W-1:0]     i_req_id,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ID_W-1:0]     o_served_id
);

    import qwmi_pkg::*;

    localparam logic [ID_W-1:0] MaxIdW = ID_W'(MAX_ID);

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [ID_W-1:0] r_id, n_id;
    logic [ID_W-1:0] r_tmp, n_tmp;
    logic [ID_W-1:0] r_head, n_head;
    logic [ID_W-1:0] r_tail, n_tail;
    logic [ID_W-1:0] r_mid, n_mid;
    logic [ID_W-1:0] r_occ, n_occ;
    logic            r_out_valid, n_out_valid;
    logic [ID_W-1:0] r_served, n_served;

    logic            ram_we;
    logic            ram_re;
    logic [ID_W-1:0] ram_addr;
    logic [ID_W-1:0] ram_wdata;
    logic [ID_W-1:0] ram_rdata;
    logic [ID_W-1:0] pop_mid;

    qwmi_ram #(
        .WIDTH(ID_W),
        .DEPTH(MAX_ID + 1)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Middle pointer after a pop: step forward on an even count, then
    // fall to the new head if the removed element was the middle.
    always_comb begin
        pop_mid = r_occ[0] ? r_mid : ram_rdata;
        if (r_head == pop_mid) begin
            pop_mid = r_tmp;
        end
    end

    // Request sequencer: at most one link memory access per cycle.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_tmp       = r_tmp;
        n_head      = r_head;
        n_tail      = r_tail;
        n_mid       = r_mid;
        n_occ       = r_occ;
        n_out_valid = r_out_valid && i_stall;
        n_served    = r_served;
        o_take      = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = r_mid;
        ram_wdata   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    o_take = 1'b1;
                    n_op   = i_req.op;
                    n_id   = i_req_id;
                    if (i_req.op == OP_POP) begin
                        // A pop of an empty queue is dropped; otherwise read the head link.
                        if (r_occ != '0) begin
                            ram_re   = 1'b1;
                            ram_addr = r_head;
                            n_state  = S_STEP1;
                        end
                    end else if (r_occ < MaxIdW) begin
                        if (r_occ == '0) begin
                            // A push into an empty queue starts a one-element list.
                            ram_we    = 1'b1;
                            ram_addr  = i_req_id;
                            ram_wdata = '0;
                            n_head    = i_req_id;
                            n_tail    = i_req_id;
                            n_mid     = i_req_id;
                            n_occ     = ID_W'(1);
                        end else begin
                            ram_re   = 1'b1;
                            ram_addr = r_mid;
                            n_state  = S_STEP1;
                        end
                    end
                end
            end
            S_STEP1: begin
                n_state = S_STEP2;
                unique case (r_op)
                    OP_PUSH_BACK: begin
                        // Terminate the new element; keep the middle's link as it
                        // will read once both link writes are done.
                        ram_we    = 1'b1;
                        ram_addr  = r_id;
                        ram_wdata = '0;
                        priority if (r_mid == r_tail) begin
                            n_tmp = r_id;
                        end else if (r_mid == r_id) begin
                            n_tmp = '0;
                        end else begin
                            n_tmp = ram_rdata;
                        end
                    end
                    OP_PUSH_MIDDLE: begin
                        // The new element takes over the middle's successor.
                        ram_we    = 1'b1;
                        ram_addr  = r_id;
                        ram_wdata = ram_rdata;
                        n_tmp     = ram_rdata;
                    end
                    OP_POP: begin
                        // Keep the new head and read the middle's link.
                        ram_re   = 1'b1;
                        ram_addr = r_mid;
                        n_tmp    = ram_rdata;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_STEP2: begin
                unique case (r_op)
                    OP_PUSH_BACK: begin
                        ram_we    = 1'b1;
                        ram_addr  = r_tail;
                        ram_wdata = r_id;
                        n_tail    = r_id;
                        n_occ     = r_occ + ID_W'(1);
                        if (!r_occ[0]) begin
                            n_mid = r_tmp;
                        end
                        n_state = S_IDLE;
                    end
                    OP_PUSH_MIDDLE: begin
                        ram_we    = 1'b1;
                        ram_addr  = r_mid;
                        ram_wdata = r_id;
                        if (r_tmp == '0) begin
                            n_tail = r_id;
                        end
                        n_occ = r_occ + ID_W'(1);
                        if (!r_occ[0]) begin
                            n_mid = r_id;
                        end
                        n_state = S_IDLE;
                    end
                    OP_POP: begin
                        // Wait here until the output register is free.
                        if (!r_out_valid || !i_stall) begin
                            n_out_valid = 1'b1;
                            n_served    = r_head;
                            n_head      = r_tmp;
                            if (r_tmp == '0) begin
                                n_tail = '0;
                            end
                            n_mid   = pop_mid;
                            n_occ   = r_occ - ID_W'(1);
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and list pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_mid       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_mid       <= n_mid;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_id     <= n_id;
        r_tmp    <= n_tmp;
        r_served <= n_served;
    end

    assign o_valid     = r_out_valid;
    assign o_served_id = r_served;

    // The count never passes the number of identifiers.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= MaxIdW)
        else $error("occupancy above the identifier range");

    // Requests are only taken while the sequencer is idle.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_state == S_IDLE))
        else $error("request taken while busy");

    // The single memory port never reads and writes in one cycle.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("link memory read and write together");

    // A finished pop waits while a previous result is still stalled.
    a_pop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP2 && r_op == OP_POP && r_out_valid && i_stall)
        |=> (r_state == S_STEP2) && $stable(r_served))
        else $error("pop finished over an unread result");

    // A pop only completes when the queue held something.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP2 && r_op == OP_POP) |-> (r_occ != '0))
        else $error("pop carried out on an empty queue");

endmodule

@@ rtl/queue_with_middle_insertion.sv @@
// A command enters the request queue at acceptance; the back part takes one command per
// visit to idle. A push into an empty queue completes in S_IDLE; other pushes and pops
// that take effect pass S_STEP1 and S_STEP2, and a pop's identifier enters the output
// register as it leaves S_STEP2. The steps are set by the single port of the link memory.
// Reset: synchronous, active low; pointers, count, queues and sequencer are cleared,
// while the link memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module queue_with_middle_insertion #(
    parameter int MAX_ID = 1023,
    parameter int ID_W   = $clog2(MAX_ID + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_command,
    input  logic [ID_W-1:0] i_item_id,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [ID_W-1:0] o_served_id
);

    import qwmi_pkg::*;

    t_req_ctl        req;
    logic [ID_W-1:0] req_id;
    logic            take;

    // Front part: request intake and classification.
    qwmi_front #(
        .MAX_ID(MAX_ID),
        .ID_W  (ID_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_command(i_command),
        .i_item_id(i_item_id),
        .o_req    (req),
        .o_req_id (req_id),
        .i_take   (take)
    );

    // Back part: list update and result delivery.
    qwmi_back #(
        .MAX_ID(MAX_ID),
        .ID_W  (ID_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_req_id   (req_id),
        .o_take     (take),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_served_id(o_served_id)
    );

endmodule

@@ test/queue_with_middle_insertion_test.sv @@
// Self-checking testbench for queue_with_middle_insertion: linked-list FIFO with
// push to back, push after middle and pop front. Depends on qwmi_pkg and the RTL;
// a built-in predictor supplies the expected served identifiers.
`timescale 1ns / 1ps

module queue_with_middle_insertion_test;
    import qwmi_pkg::*;

    localparam int ID_W = 10;
    localparam int MAX_ID = 1023;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 8;
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_POPS = 600;
    // Command code that the block ignores.
    localparam logic [1:0] CMD_NONE = 2'd3;
    // Index of the planner copy and of the checker copy of the queue state.
    localparam int PLAN = 0;
    localparam int CHECK = 1;

    typedef logic [ID_W-1:0] t_id;

    typedef struct {
        logic [1:0] command;
        t_id        item_id;
        bit         eager;
        bit         hold;
    } t_request;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_command = '0;
    t_id        i_item_id = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_id        o_served_id;

    // Two copies of the queue: one steers stimulus, one predicts served identifiers.
    t_id link_mem [2][1024];
    bit  link_set [2][1024];
    t_id head_id [2] = '{default: '0};
    t_id tail_id [2] = '{default: '0};
    t_id mid_id [2] = '{default: '0};
    t_id depth [2] = '{default: '0};

    t_request pending[$];
    t_id      served_q[$];
    int       failures = 0;
    int       results = 0;
    int       cycles = 0;
    int       gap_left = 0;
    int       hold_left = HOLD_CYCLES;
    int       stall_left = 0;
    bit       rx_eager = 1'b0;

    queue_with_middle_insertion dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_item_id   (i_item_id),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_served_id (o_served_id)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void put_link(input int m, input t_id at, input t_id value);
        link_mem[m][at] = value;
        link_set[m][at] = 1'b1;
    endfunction

    // Applies one request to copy m; returns 1 when the request changes the queue.
    function automatic bit advance_queue(input int m, input logic [1:0] cmd, input t_id id,
                                         output t_id served);
        t_id after;
        t_id removed;
        served = '0;
        if (cmd == CMD_POP) begin
            if (depth[m] == 0) return 1'b0;
            removed = head_id[m];
            head_id[m] = link_mem[m][removed];
            if (head_id[m] == 0) tail_id[m] = '0;
            if (!depth[m][0]) mid_id[m] = link_mem[m][mid_id[m]];
            if (removed == mid_id[m]) mid_id[m] = head_id[m];
            depth[m] = depth[m] - 1'b1;
            served = removed;
            return 1'b1;
        end
        if (cmd != CMD_PUSH_BACK && cmd != CMD_PUSH_MIDDLE) return 1'b0;
        if (id == 0 || depth[m] >= MAX_ID) return 1'b0;
        if (depth[m] == 0) begin
            // A push into an empty queue starts a one-element list.
            head_id[m] = id;
            tail_id[m] = id;
            mid_id[m] = id;
            put_link(m, id, '0);
            depth[m] = t_id'(1);
            return 1'b1;
        end
        if (cmd == CMD_PUSH_BACK) begin
            put_link(m, id, '0);
            put_link(m, tail_id[m], id);
            tail_id[m] = id;
        end else begin
            after = link_mem[m][mid_id[m]];
            put_link(m, id, after);
            put_link(m, mid_id[m], id);
            if (after == 0) tail_id[m] = id;
        end
        depth[m] = depth[m] + 1'b1;
        if (depth[m][0]) mid_id[m] = link_mem[m][mid_id[m]];
        return 1'b1;
    endfunction

    // True when the request reads only link entries that have been written.
    function automatic bit reads_written(input int m, input logic [1:0] cmd, input t_id id);
        if (cmd == CMD_POP)
            return depth[m] == 0 ||
                   (link_set[m][head_id[m]] && (depth[m][0] || link_set[m][mid_id[m]]));
        if (cmd == CMD_NONE || id == 0 || depth[m] == 0 || depth[m] >= MAX_ID) return 1'b1;
        if (cmd == CMD_PUSH_MIDDLE) return link_set[m][mid_id[m]];
        return depth[m][0] || mid_id[m] == id || mid_id[m] == tail_id[m] ||
               link_set[m][mid_id[m]];
    endfunction

    // Queues one request for the driver; a request that would read a link entry
    // never written is turned into an ignored command.
    function automatic bit queue_up(input logic [1:0] cmd, input t_id id, input bit eager);
        t_request req;
        t_id      unused;
        if (!reads_written(PLAN, cmd, id)) cmd = CMD_NONE;
        req.command = cmd;
        req.item_id = id;
        req.eager = eager;
        req.hold = 1'b0;
        pending.push_back(req);
        return advance_queue(PLAN, cmd, id, unused);
    endfunction

    // The driver stops here until every pop it sent has been served.
    function automatic void pause_for_results();
        t_request req;
        req.command = CMD_NONE;
        req.item_id = '0;
        req.eager = 1'b0;
        req.hold = 1'b1;
        pending.push_back(req);
    endfunction

    // Request driver: predicts on acceptance and applies sender gaps.
    always @(posedge i_clk) begin : drive
        t_request req;
        t_id      served;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
            hold_left = HOLD_CYCLES;
        end else begin
            if (i_valid && !o_stall) begin
                if (advance_queue(CHECK, i_command, i_item_id, served) &&
                    i_command == CMD_POP)
                    served_q.push_back(served);
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending[0].hold) begin
                    i_valid <= 1'b0;
                    if (served_q.size() != 0) begin
                        hold_left = HOLD_CYCLES;
                    end else if (hold_left != 0) begin
                        hold_left--;
                    end else begin
                        pending.delete(0);
                        hold_left = HOLD_CYCLES;
                    end
                end else begin
                    req = pending.pop_front();
                    i_valid <= 1'b1;
                    i_command <= req.command;
                    i_item_id <= req.item_id;
                    gap_left = req.eager ? 0 : $urandom_range(0, 3);
                end
            end
        end
    end

    // Result monitor: compares each served identifier and applies receiver stalls.
    always @(posedge i_clk) begin : receive
        t_id want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (served_q.size() == 0) begin
                    $display("%0t: served_id expected none, got %0d", $time, o_served_id);
                    failures++;
                end else begin
                    want = served_q.pop_front();
                    if (o_served_id !== want) begin
                        $display("%0t: served_id expected %0d, got %0d",
                                 $time, want, o_served_id);
                        failures++;
                    end
                end
                results++;
                if (results % 64 == 0) rx_eager = ($urandom_range(0, 2) == 0);
                stall_left = rx_eager ? 0 : $urandom_range(0, 3);
            end else if (o_valid && stall_left != 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("queue_with_middle_insertion: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        t_id        order [MAX_ID];
        t_id        swap;
        t_id        id;
        t_id        first;
        logic [1:0] cmd;
        int         j;
        int         counted;
        int         push_pct;
        bit         eager;

        // Directed: ignored commands, field extremes and both push kinds.
        void'(queue_up(CMD_POP, '0, 1'b0));
        void'(queue_up(CMD_NONE, 10'd5, 1'b0));
        void'(queue_up(CMD_PUSH_BACK, '0, 1'b0));
        void'(queue_up(CMD_PUSH_MIDDLE, '0, 1'b0));
        void'(queue_up(CMD_PUSH_MIDDLE, 10'd1023, 1'b0));
        void'(queue_up(CMD_PUSH_BACK, 10'd1, 1'b1));
        void'(queue_up(CMD_PUSH_MIDDLE, 10'd2, 1'b1));
        void'(queue_up(CMD_PUSH_BACK, 10'd3, 1'b0));
        void'(queue_up(CMD_PUSH_MIDDLE, 10'd4, 1'b0));
        for (int k = 0; k < 6; k++) void'(queue_up(CMD_POP, '0, k[0]));

        // A duplicate identifier corrupts the list; the pops that follow serve
        // identifier zero and the link entry of identifier zero gets written.
        void'(queue_up(CMD_PUSH_BACK, 10'd10, 1'b0));
        void'(queue_up(CMD_PUSH_BACK, 10'd11, 1'b0));
        void'(queue_up(CMD_PUSH_BACK, 10'd10, 1'b0));
        void'(queue_up(CMD_POP, '0, 1'b0));
        void'(queue_up(CMD_PUSH_BACK, 10'd12, 1'b0));
        for (int k = 0; k < 3; k++) void'(queue_up(CMD_POP, '0, 1'b0));
        pause_for_results();

        // Fill to the limit with every identifier once, in shuffled order.
        for (int k = 0; k < MAX_ID; k++) order[k] = t_id'(k + 1);
        for (int k = MAX_ID - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            swap = order[k];
            order[k] = order[j];
            order[j] = swap;
        end
        for (int k = 0; k < MAX_ID; k++) begin
            cmd = $urandom_range(0, 1) ? CMD_PUSH_MIDDLE : CMD_PUSH_BACK;
            void'(queue_up(cmd, order[k], (k % 256) < 64));
        end
        // Pushes into a full queue are dropped.
        void'(queue_up(CMD_PUSH_BACK, order[0], 1'b0));
        void'(queue_up(CMD_PUSH_MIDDLE, 10'd1023, 1'b0));
        pause_for_results();
        first = head_id[PLAN];
        void'(queue_up(CMD_POP, '0, 1'b0));
        void'(queue_up(CMD_PUSH_MIDDLE, first, 1'b0));
        for (int k = 0; k < DRAIN_POPS; k++) void'(queue_up(CMD_POP, '0, (k % 300) < 100));
        pause_for_results();

        // Random segments that alternately grow and drain the queue.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0: push_pct = 75;
                1: push_pct = 50;
                default: push_pct = 25;
            endcase
            eager = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 60; k++) begin
                id = t_id'($urandom_range(1, MAX_ID));
                if ($urandom_range(0, 99) < 2) begin
                    cmd = CMD_NONE;
                    id = t_id'($urandom_range(0, MAX_ID));
                end else if ($urandom_range(0, 99) < push_pct) begin
                    cmd = $urandom_range(0, 1) ? CMD_PUSH_MIDDLE : CMD_PUSH_BACK;
                    j = $urandom_range(0, 99);
                    if (j < 2) begin
                        id = '0;
                    end else if (j < 5) begin
                        // Duplicate of an identifier already queued.
                        case ($urandom_range(0, 2))
                            0: id = head_id[PLAN];
                            1: id = tail_id[PLAN];
                            default: id = mid_id[PLAN];
                        endcase
                    end
                end else begin
                    cmd = CMD_POP;
                end
                counted += queue_up(cmd, id, eager);
            end
            if ($urandom_range(0, 5) == 0) pause_for_results();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last request and the last served identifier.
        while (pending.size() != 0 || i_valid || served_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0 && served_q.size() == 0)
            $display("queue_with_middle_insertion: match");
        else
            $display("queue_with_middle_insertion: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/qwmi_pkg.sv
rtl/qwmi_ram.sv
rtl/qwmi_front.sv
rtl/qwmi_back.sv
rtl/queue_with_middle_insertion.sv
test/queue_with_middle_insertion_test.sv
